>>> hw/rtl/pcsm_pkg.sv
// Package with types, constants and opcode codes for the p-code stack machine executor.
package pcsm_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned CODE_DEPTH_DEF  = 4096;

  typedef enum logic [2:0] {
    FN_LIT = 3'd0,
    FN_LOD = 3'd1,
    FN_STO = 3'd2,
    FN_CAL = 3'd3,
    FN_INT = 3'd4,
    FN_JMP = 3'd5,
    FN_JPC = 3'd6,
    FN_OPR = 3'd7
  } func_t;

  localparam logic [3:0] OP_RET   = 4'd0;
  localparam logic [3:0] OP_NEG   = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_ODD   = 4'd6;
  localparam logic [3:0] OP_EQU   = 4'd7;
  localparam logic [3:0] OP_NEQ   = 4'd8;
  localparam logic [3:0] OP_LSS   = 4'd9;
  localparam logic [3:0] OP_GEQ   = 4'd10;
  localparam logic [3:0] OP_GTR   = 4'd11;
  localparam logic [3:0] OP_LEQ   = 4'd12;
  localparam logic [3:0] OP_WRITE = 4'd13;
  localparam logic [3:0] OP_LINE  = 4'd14;
  localparam logic [3:0] OP_READ  = 4'd15;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_ADDR = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  level;
    logic signed [31:0] operand;
    logic signed [31:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic        write_valid;
    logic signed [31:0] write_value;
    logic        newline;
    logic        halted;
    logic [1:0]  error_code;
  } out_item_t;

endpackage

>>> hw/rtl/pcsm_ram.sv
// Generic single-port RAM with registered read.
module pcsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/pcsm_div.sv
// Radix-2 restoring divider for signed 32-bit truncating division.
module pcsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, q_r[31]};
    trial    = shifted - {1'b0, dv_r};
    if (start && !busy_r) begin
      q_nxt    = dividend[31] ? (32'd0 - dividend) : dividend;
      dv_nxt   = divisor[31] ? (32'd0 - divisor) : divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      neg_nxt  = dividend[31] ^ divisor[31];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - q_r) : q_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> (busy_r || done_r))
    else $error("divider stopped without done");
  a_count_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r == 6'd0) || $past(start))
    else $error("divider count left over");
endmodule

>>> hw/rtl/pcode_stack_machine_executor.sv
// Top level of the PL/0 p-code stack machine executor.
//
// The block executes one p-code instruction per input transaction. The input
// channel (in_valid/in_ready/in_data) carries func, level, operand and a value
// for READ. The output channel (out_valid/out_ready/out_data) returns one
// result transaction per instruction: the next code address, a WRITE value,
// a newline request, the halt flag and an error code.
// A small sequencer drives one stack memory port per cycle. From the accepting
// edge the result passes a decode state and an output state, plus an address
// and a data state per stack word read, a write state per word written, an
// execute state after reads and a link and a wait state per static level
// followed; a divide also waits in a state of its own for the divider.
// in_ready stays low until the result has been taken, so the next
// transaction can be accepted in the cycle after that.
// After reset the block first sweeps the data stack to zero, one word per
// cycle, and in_ready stays low until the sweep is done.
// The result sits in an output register; if the receiver stalls the block
// holds it and accepts no new instruction until it has been taken.
// Once pc returns to zero the result reports halted; further instructions
// simply continue from address zero.
module pcode_stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = pcsm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned CODE_DEPTH  = pcsm_pkg::CODE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcsm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcsm_pkg::out_item_t out_data
);
  import pcsm_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned TW = AW + 1;
  localparam int unsigned PW = $clog2(CODE_DEPTH);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DEC   = 11'b00000000100,
    S_LINK  = 11'b00000001000,
    S_LWAIT = 11'b00000010000,
    S_RD1   = 11'b00000100000,
    S_RD2   = 11'b00001000000,
    S_EXEC  = 11'b00010000000,
    S_WR    = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  in_item_t       ins_r, ins_nxt;
  logic [TW-1:0]  top_r, top_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [PW-1:0]  pc_r, pc_nxt;
  logic [AW:0]    clr_r, clr_nxt;
  logic [7:0]     lev_r, lev_nxt;
  logic [AW-1:0]  chain_r, chain_nxt;
  logic [31:0]    a_r, a_nxt;     // first operand or word read
  logic [31:0]    b_r, b_nxt;     // second operand
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [1:0]     wcnt_r, wcnt_nxt;
  logic [1:0]     rcnt_r, rcnt_nxt;
  out_item_t      res_r, res_nxt;
  logic           ovld_r, ovld_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [31:0]    ram_wdata, ram_rdata;
  logic           div_start;
  logic           div_busy;
  logic           div_done;
  logic [31:0]    div_q;

  pcsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  pcsm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(a_r), .divisor(b_r),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  // Decode helpers.
  logic [3:0]   sub;
  logic         sub_ok;
  logic         is_bin;
  logic         is_un;
  logic signed [33:0] op_s;
  logic signed [33:0] fa_s;
  logic signed [33:0] nt_s;
  logic [PW-1:0] tgt_pc;
  logic signed [31:0] sa, sb;
  logic [31:0]  bin_r;

  assign sub    = ins_r.operand[3:0];
  assign sub_ok = (ins_r.operand[31:4] == '0);
  assign is_un  = (sub == OP_NEG) || (sub == OP_ODD) || (sub == OP_WRITE);
  assign is_bin = !is_un && (sub != OP_RET) && (sub != OP_LINE) && (sub != OP_READ);
  assign op_s   = 34'(ins_r.operand);
  assign fa_s   = $signed(34'(chain_r)) + op_s;
  assign nt_s   = $signed(34'(top_r)) + op_s;
  assign tgt_pc = ins_r.operand[PW-1:0];
  assign sa     = a_r;
  assign sb     = b_r;

  always_comb begin
    bin_r = '0;
    unique case (sub)
      OP_ADD:  bin_r = a_r + b_r;
      OP_SUB:  bin_r = a_r - b_r;
      OP_MUL:  bin_r = a_r * b_r;
      OP_EQU:  bin_r = {31'd0, sa == sb};
      OP_NEQ:  bin_r = {31'd0, sa != sb};
      OP_LSS:  bin_r = {31'd0, sa < sb};
      OP_GEQ:  bin_r = {31'd0, sa >= sb};
      OP_GTR:  bin_r = {31'd0, sa > sb};
      OP_LEQ:  bin_r = {31'd0, sa <= sb};
      default: bin_r = div_q;
    endcase
  end

  function automatic logic [AW-1:0] ta(input logic [TW-1:0] v);
    return v[AW-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    ins_nxt   = ins_r;
    top_nxt   = top_r;
    base_nxt  = base_r;
    pc_nxt    = pc_r;
    clr_nxt   = clr_r;
    lev_nxt   = lev_r;
    chain_nxt = chain_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    addr_nxt  = addr_r;
    wcnt_nxt  = wcnt_r;
    rcnt_nxt  = rcnt_r;
    res_nxt   = res_r;
    ovld_nxt  = ovld_r;
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = '0;
    div_start = 1'b0;

    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r[AW-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == (AW+1)'(STACK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !ovld_r) begin
          ins_nxt   = in_data;
          pc_nxt    = PW'(pc_r + 1'b1);
          res_nxt   = '0;
          lev_nxt   = in_data.level;
          chain_nxt = base_r;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        // Checks that need no memory, then choose the route.
        state_nxt = S_OUT;
        unique case (func_t'(ins_r.func))
          FN_LIT: begin
            if (top_r >= TW'(STACK_DEPTH)) res_nxt.error_code = ERR_ADDR;
            else begin
              addr_nxt = ta(top_r); a_nxt = ins_r.operand; wcnt_nxt = 2'd1;
              state_nxt = S_WR;
            end
          end
          FN_LOD, FN_STO, FN_CAL: begin
            if ((ins_r.func == FN_LOD && top_r >= TW'(STACK_DEPTH)) ||
                (ins_r.func == FN_STO && (top_r < TW'(1))) ||
                (ins_r.func == FN_CAL &&
                 ({1'b0, top_r} + (TW+1)'(2) >= (TW+1)'(STACK_DEPTH)))) begin
              res_nxt.error_code = ERR_ADDR;
            end else begin
              state_nxt = S_LINK;
            end
          end
          FN_INT: begin
            if (nt_s < 0 || nt_s > 34'sd0 + $signed(34'(STACK_DEPTH)))
              res_nxt.error_code = ERR_ADDR;
            else top_nxt = nt_s[TW-1:0];
          end
          FN_JMP: pc_nxt = tgt_pc;
          FN_JPC: begin
            if (top_r < TW'(1)) res_nxt.error_code = ERR_ADDR;
            else begin
              addr_nxt = ta(top_r - 1'b1); rcnt_nxt = 2'd1; state_nxt = S_RD1;
            end
          end
          default: begin
            if (!sub_ok) begin
              state_nxt = S_OUT;
            end else if (sub == OP_LINE) begin
              res_nxt.newline = 1'b1;
            end else if (sub == OP_READ) begin
              if (top_r >= TW'(STACK_DEPTH)) res_nxt.error_code = ERR_ADDR;
              else begin
                addr_nxt = ta(top_r); a_nxt = ins_r.read_value; wcnt_nxt = 2'd1;
                state_nxt = S_WR;
              end
            end else if (sub == OP_RET) begin
              if ({1'b0, base_r} + (AW+1)'(2) >= (AW+1)'(STACK_DEPTH))
                res_nxt.error_code = ERR_ADDR;
              else begin
                addr_nxt = base_r; rcnt_nxt = 2'd2; state_nxt = S_RD1;
              end
            end else if (is_un) begin
              if (top_r < TW'(1)) res_nxt.error_code = ERR_ADDR;
              else begin
                addr_nxt = ta(top_r - 1'b1); rcnt_nxt = 2'd1; state_nxt = S_RD1;
              end
            end else begin
              if (top_r < TW'(2)) res_nxt.error_code = ERR_ADDR;
              else begin
                addr_nxt = ta(top_r - 2'd2); rcnt_nxt = 2'd2; state_nxt = S_RD1;
              end
            end
          end
        endcase
      end
      S_LINK: begin
        // One static link per pass: address chain + 1.
        if (lev_r == 8'd0) begin
          if (ins_r.func == FN_CAL) begin
            addr_nxt = ta(top_r); a_nxt = 32'(base_r); b_nxt = 32'(chain_r);
            wcnt_nxt = 2'd3; state_nxt = S_WR;
          end else if (fa_s < 0 || fa_s >= $signed(34'(STACK_DEPTH))) begin
            res_nxt.error_code = ERR_ADDR; state_nxt = S_OUT;
          end else if (ins_r.func == FN_LOD) begin
            addr_nxt = fa_s[AW-1:0]; rcnt_nxt = 2'd1; state_nxt = S_RD1;
          end else begin
            addr_nxt = ta(top_r - 1'b1); b_nxt = {{(32-AW){1'b0}}, fa_s[AW-1:0]};
            rcnt_nxt = 2'd1; state_nxt = S_RD1;
          end
        end else if ({1'b0, chain_r} + (AW+1)'(1) >= (AW+1)'(STACK_DEPTH)) begin
          res_nxt.error_code = ERR_ADDR; state_nxt = S_OUT;
        end else begin
          ram_addr  = chain_r + 1'b1;
          state_nxt = S_LWAIT;
        end
      end
      S_LWAIT: begin
        if (ram_rdata >= 32'(STACK_DEPTH)) begin
          res_nxt.error_code = ERR_ADDR; state_nxt = S_OUT;
        end else begin
          chain_nxt = ram_rdata[AW-1:0];
          lev_nxt   = lev_r - 1'b1;
          state_nxt = S_LINK;
        end
      end
      S_RD1: begin
        // Address presented; data arrives next cycle.
        ram_addr  = addr_r;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        rcnt_nxt = rcnt_r - 1'b1;
        if (rcnt_r == 2'd2) begin
          a_nxt = ram_rdata;
          addr_nxt = (ins_r.func == FN_OPR && sub == OP_RET) ? addr_r + 2'd2
                                                             : addr_r + 1'b1;
          state_nxt = S_RD1;
        end else begin
          if (ins_r.func == FN_OPR && sub == OP_RET) b_nxt = ram_rdata;
          else if (ins_r.func == FN_OPR && is_bin) b_nxt = ram_rdata;
          else a_nxt = ram_rdata;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        unique case (func_t'(ins_r.func))
          FN_LOD: begin
            addr_nxt = ta(top_r); wcnt_nxt = 2'd1; state_nxt = S_WR;
          end
          FN_STO: begin
            addr_nxt = b_r[AW-1:0]; wcnt_nxt = 2'd1; state_nxt = S_WR;
          end
          FN_JPC: begin
            if (a_r == '0) pc_nxt = tgt_pc;
          end
          default: begin
            if (sub == OP_RET) begin
              if (a_r >= 32'(STACK_DEPTH)) res_nxt.error_code = ERR_ADDR;
              else begin
                top_nxt  = TW'(base_r);
                pc_nxt   = b_r[PW-1:0];
                base_nxt = a_r[AW-1:0];
              end
            end else if (sub == OP_WRITE) begin
              res_nxt.write_valid = 1'b1;
              res_nxt.write_value = a_r;
            end else if (is_un) begin
              a_nxt = (sub == OP_NEG) ? 32'd0 - a_r : {31'd0, a_r[0]};
              addr_nxt = ta(top_r - 1'b1); wcnt_nxt = 2'd1; state_nxt = S_WR;
            end else if (sub == OP_DIV) begin
              if (b_r == '0) res_nxt.error_code = ERR_DIV0;
              else begin
                div_start = 1'b1; state_nxt = S_DIV;
              end
            end else begin
              a_nxt = bin_r; addr_nxt = ta(top_r - 2'd2); wcnt_nxt = 2'd1;
              state_nxt = S_WR;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          a_nxt = div_q; addr_nxt = ta(top_r - 2'd2); wcnt_nxt = 2'd1;
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        ram_we   = 1'b1;
        ram_addr = addr_r;
        unique case (wcnt_r)
          2'd3:    ram_wdata = a_r;
          2'd2:    ram_wdata = b_r;
          default: ram_wdata = (ins_r.func == FN_CAL) ? 32'(pc_r) : a_r;
        endcase
        addr_nxt = addr_r + 1'b1;
        wcnt_nxt = wcnt_r - 1'b1;
        if (wcnt_r == 2'd1) begin
          state_nxt = S_OUT;
          unique case (func_t'(ins_r.func))
            FN_LIT, FN_LOD: top_nxt = top_r + 1'b1;
            FN_STO:         top_nxt = top_r - 1'b1;
            FN_CAL: begin
              base_nxt = ta(top_r); pc_nxt = tgt_pc;
            end
            default: begin
              if (sub == OP_READ) top_nxt = top_r + 1'b1;
              else if (is_bin) top_nxt = top_r - 1'b1;
            end
          endcase
        end
      end
      default: begin
        // Output stage: publish the result.
        res_nxt.next_pc = 12'(pc_r);
        res_nxt.halted  = (pc_r == '0);
        ovld_nxt        = 1'b1;
        state_nxt       = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      top_r   <= '0;
      base_r  <= '0;
      pc_r    <= '0;
      clr_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      base_r  <= base_nxt;
      pc_r    <= pc_nxt;
      clr_r   <= clr_nxt;
      ovld_r  <= ovld_nxt;
    end
    ins_r   <= ins_nxt;
    lev_r   <= lev_nxt;
    chain_r <= chain_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    addr_r  <= addr_nxt;
    wcnt_r  <= wcnt_nxt;
    rcnt_r  <= rcnt_nxt;
    res_r   <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE) && !ovld_r;
  assign out_valid = ovld_r;
  assign out_data  = res_r;

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(STACK_DEPTH))
    else $error("stack top beyond stack depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DEC))
    else $error("accepted transaction not decoded");
  a_out_after_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> $past(state_r == S_OUT))
    else $error("result published outside output stage");
  a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (res_r.error_code == ERR_NONE))
    else $error("stack written despite error");
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider running outside the divide wait");
endmodule
